@@ hw/rtl/bitmap_slot_alloc_ordered_insert_top_defines.svh @@
// assertion macros used by the checker file
`ifndef BITMAP_SLOT_ALLOC_ORDERED_INSERT_TOP_DEFINES_SVH
`define BITMAP_SLOT_ALLOC_ORDERED_INSERT_TOP_DEFINES_SVH

// property sampled on clk, switched off while rst is high
`define BSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bsa assertion failed");

// same with a caller supplied message
`define BSA_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`endif

@@ hw/rtl/bsa_pkg.sv @@
`default_nettype none

package bsa_pkg;

  localparam int SLOT_COUNT_DEF = 128;

  localparam int POS_W    = 7;
  localparam int SLOT_W   = 7;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 8;

  // free slot search runs over groups of this many bits
  localparam int GRP_W     = 16;
  localparam int GRP_IDX_W = 4;

  localparam logic [ENTRY_W-1:0] NULL_MARK = 8'hFF;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 8'hFF;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/bsa_req_if.sv @@
`default_nettype none

interface bsa_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [bsa_pkg::POS_W-1:0] position;

  modport source (output valid, output req_type, output position, input ready);
  modport sink   (input valid, input req_type, input position, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bsa_rsp_if.sv @@
`default_nettype none

interface bsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bsa_pkg::STATUS_W-1:0] status;
  logic [bsa_pkg::SLOT_W-1:0]   slot;
  logic [bsa_pkg::CNT_W-1:0]    step_number;
  logic [bsa_pkg::CNT_W-1:0]    live_count;

  modport source (output valid, output status, output slot, output step_number,
                  output live_count, input ready);
  modport sink   (input valid, input status, input slot, input step_number,
                  input live_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bsa_ctrl.sv @@
`default_nettype none

module bsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output bsa_pkg::cmd_t      cmd,
  input  wire bsa_pkg::stat_t stat
);
  import bsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_COMMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // wait while the previous word still sits in the output register
        if (!stat.out_hold) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bsa_datapath.sv @@
`default_nettype none

module bsa_datapath #(
  parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bsa_pkg::cmd_t              cmd,
  output bsa_pkg::stat_t                  stat,
  input  wire logic                       in_req_type,
  input  wire logic [bsa_pkg::POS_W-1:0]  in_position,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [bsa_pkg::STATUS_W-1:0]    out_status,
  output logic [bsa_pkg::SLOT_W-1:0]      out_slot,
  output logic [bsa_pkg::CNT_W-1:0]       out_step_number,
  output logic [bsa_pkg::CNT_W-1:0]       out_live_count
);
  import bsa_pkg::*;

  localparam int NGROUP = (SLOT_COUNT + GRP_W - 1) / GRP_W;
  localparam int SEL_W  = (NGROUP > 1) ? $clog2(NGROUP) : 1;
  localparam int IDX_W  = SEL_W + GRP_IDX_W;
  localparam int PAD_W  = NGROUP * GRP_W;

  logic                  req_type;
  logic [POS_W-1:0]      position;

  logic [SLOT_COUNT-1:0] used;
  logic [ENTRY_W-1:0]    tbl [SLOT_COUNT];
  logic [ENTRY_W-1:0]    tbl_prev [SLOT_COUNT];
  logic [CNT_W-1:0]      cnt;

  logic [PAD_W-1:0]      eff_map;
  logic [NGROUP-1:0]     grp_any;
  logic [GRP_IDX_W-1:0]  grp_idx [NGROUP];
  logic [NGROUP-1:0]     grp_any_next;
  logic [GRP_IDX_W-1:0]  grp_idx_next [NGROUP];

  logic                  found;
  logic [SEL_W-1:0]      sel;
  logic [IDX_W-1:0]      slot_idx;
  logic [ENTRY_W-1:0]    slot_ext;
  logic [CNT_W-1:0]      pos_ext;
  logic                  pos_bad;
  logic                  ins_ok;
  logic [CNT_W-1:0]      cnt_inc;
  logic [SLOT_COUNT-1:0] slot_oh;

  assign stat.out_hold = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type <= in_req_type;
      position <= in_position;
    end
  end

  // an empty list frees the whole bitmap; slots past the store read as used
  always_comb begin
    eff_map = '1;
    eff_map[SLOT_COUNT-1:0] = (cnt == '0) ? '0 : used;
  end

  // first search level: lowest free bit within each group, registered every cycle
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_any_next[g] = 1'b0;
      grp_idx_next[g] = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (!eff_map[g*GRP_W + b]) begin
          grp_any_next[g] = 1'b1;
          grp_idx_next[g] = GRP_IDX_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_next;
    for (int g = 0; g < NGROUP; g++) begin
      grp_idx[g] <= grp_idx_next[g];
    end
  end

  // second level: lowest group with a free bit
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int g = NGROUP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found = 1'b1;
        sel   = SEL_W'(g);
      end
    end
  end

  assign slot_idx = {sel, grp_idx[sel]};
  assign slot_ext = ENTRY_W'(slot_idx);
  assign pos_ext  = CNT_W'(position);
  assign pos_bad  = (pos_ext >= CNT_W'(SLOT_COUNT));
  assign ins_ok   = cmd.commit && (req_type == REQ_INSERT) && !pos_bad && found;
  assign cnt_inc  = (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_oh[i] = (slot_idx == IDX_W'(i));
    end
  end

  generate
    for (genvar gi = 0; gi < SLOT_COUNT; gi++) begin : g_prev
      if (gi == 0) begin : g_first
        assign tbl_prev[gi] = NULL_MARK;
      end else begin : g_rest
        assign tbl_prev[gi] = tbl[gi-1];
      end
    end
  endgenerate

  // list state: bitmap, order table, count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      cnt  <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tbl[i] <= NULL_MARK;
      end
    end else if (cmd.commit && (req_type == REQ_CLEAR)) begin
      used <= '0;
      cnt  <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tbl[i] <= NULL_MARK;
      end
    end else if (ins_ok) begin
      used <= ((cnt == '0) ? '0 : used) | slot_oh;
      cnt  <= cnt_inc;
      // entries from position up to the count move up one place
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (CNT_W'(i) == pos_ext) begin
          tbl[i] <= slot_ext;
        end else if ((CNT_W'(i) > pos_ext) && (CNT_W'(i) <= cnt)) begin
          tbl[i] <= tbl_prev[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req_type == REQ_CLEAR) begin
        out_status      <= ST_DONE;
        out_slot        <= '0;
        out_step_number <= '0;
        out_live_count  <= '0;
      end else if (pos_bad) begin
        out_status      <= ST_RANGE;
        out_slot        <= '0;
        out_step_number <= '0;
        out_live_count  <= cnt;
      end else if (!found) begin
        out_status      <= ST_FULL;
        out_slot        <= '0;
        out_step_number <= '0;
        out_live_count  <= cnt;
      end else begin
        out_status      <= ST_DONE;
        out_slot        <= slot_ext[SLOT_W-1:0];
        out_step_number <= pos_ext + CNT_W'(1);
        out_live_count  <= cnt_inc;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_slot_alloc_ordered_insert_top.sv @@
// Step slot allocator with an ordered position table.
//
// Channel req (sink): req_type 0 inserts a step at position, 1 clears all
// slots, the order table and the count. Channel rsp (source): one word per
// request with status (done, position out of range, no free slot), the
// claimed slot, the step number and the live count after the request.
//
// Timing: an accepted request is taken into the input register and resolved in
// the commit state, where its response word is loaded into the output register;
// the commit waits while a held word still sits there. req.ready drops while a
// request is resolved, so no new request is taken before it. The lowest free slot comes from a two level
// search, a per-group find registered every cycle and a group select in the
// resolve cycle; the table shift is done in parallel on all entries.
//
// Reset: all slots free, table entries at the null marker, count zero;
// req.ready is high in the first cycle after reset.
// Stall: while rsp.ready is low the response word holds; one more request
// may be accepted, but it is not resolved until the held word is taken.
`default_nettype none

module bitmap_slot_alloc_ordered_insert_top #(
  parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  bsa_req_if.sink   req,
  bsa_rsp_if.source rsp
);
  import bsa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bsa_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (req.req_type),
    .in_position     (req.position),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_slot        (rsp.slot),
    .out_step_number (rsp.step_number),
    .out_live_count  (rsp.live_count)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bsa_checker.sv @@
`default_nettype none

`include "bitmap_slot_alloc_ordered_insert_top_defines.svh"

module bsa_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           req_valid,
  input wire logic                           req_ready,
  input wire logic                           rsp_valid,
  input wire logic                           rsp_ready,
  input wire logic [bsa_pkg::STATUS_W-1:0]   rsp_status,
  input wire logic [bsa_pkg::SLOT_W-1:0]     rsp_slot,
  input wire logic [bsa_pkg::CNT_W-1:0]      rsp_step_number,
  input wire logic [bsa_pkg::CNT_W-1:0]      rsp_live_count
);
  import bsa_pkg::*;

  // a held word keeps its status, slot and live count
  `BSA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_live_count))

  // one request in flight: ready drops for the resolve cycle
  `BSA_ASSERT_MSG(a_one_in_flight, req_valid && req_ready |=> !req_ready, "request accepted during resolve")

  // failed requests report neither slot nor step
  `BSA_ASSERT_MSG(a_err_zero, rsp_valid && rsp_status != ST_DONE |-> rsp_slot == '0 && rsp_step_number == '0, "error word carries slot data")

  // a successful insert leaves at least one live step
  `BSA_ASSERT(a_ins_count, rsp_valid && rsp_status == ST_DONE && rsp_step_number != '0 |-> rsp_live_count != '0)

  `BSA_ASSERT(a_status_code, rsp_valid |-> rsp_status == ST_DONE || rsp_status == ST_RANGE || rsp_status == ST_FULL)

endmodule

bind bitmap_slot_alloc_ordered_insert_top bsa_checker u_bsa_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_slot        (rsp.slot),
  .rsp_step_number (rsp.step_number),
  .rsp_live_count  (rsp.live_count)
);

`default_nettype wire

@@ verif/bitmap_slot_alloc_ordered_insert_top_tb.sv @@
`default_nettype none

module bitmap_slot_alloc_ordered_insert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEF;
  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    step_number;
    logic [CNT_W-1:0]    live_count;
  } reply_t;

  // mirror of the slot store plus the replies still owed by the block
  class slot_ledger;
    bit                 used[SLOTS];
    logic [ENTRY_W-1:0] order[SLOTS];
    logic [CNT_W-1:0]   step_total;
    reply_t             due_replies[$];
    int                 n_errors;
    int                 n_checked;
    int                 n_placed;
    int                 n_full;
    int                 n_clears;
    int                 deepest;

    function new();
      wipe();
      n_errors  = 0;
      n_checked = 0;
      n_placed  = 0;
      n_full    = 0;
      n_clears  = 0;
      deepest   = 0;
    endfunction

    function void wipe();
      foreach (used[i]) used[i] = 1'b0;
      foreach (order[i]) order[i] = NULL_MARK;
      step_total = '0;
    endfunction

    function void note_request(logic kind, logic [POS_W-1:0] pos);
      reply_t r;
      int     free_idx;
      r = '0;
      if (kind == REQ_CLEAR) begin
        wipe();
        r.status = ST_DONE;
        n_clears++;
      end else if (int'(pos) >= SLOTS) begin
        r.status     = ST_RANGE;
        r.live_count = step_total;
      end else begin
        // empty list starts from a clean bitmap
        if (step_total == '0) begin
          foreach (used[i]) used[i] = 1'b0;
        end
        free_idx = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!used[i]) begin
            free_idx = i;
            break;
          end
        end
        if (free_idx < 0) begin
          r.status     = ST_FULL;
          r.live_count = step_total;
          n_full++;
        end else begin
          used[free_idx] = 1'b1;
          for (int i = int'(step_total); i > int'(pos); i--) begin
            if (i < SLOTS) order[i] = order[i-1];
          end
          order[pos] = ENTRY_W'(free_idx);
          if (step_total != CNT_MAX) step_total = step_total + 1'b1;
          r.status      = ST_DONE;
          r.slot        = SLOT_W'(free_idx);
          r.step_number = {1'b0, pos} + 8'd1;
          r.live_count  = step_total;
          n_placed++;
          if (int'(step_total) > deepest) deepest = int'(step_total);
        end
      end
      due_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected word, expected none, got status %0h slot %0h step %0h count %0h",
                 $time, got.status, got.slot, got.step_number, got.live_count);
        n_errors++;
        return;
      end
      want = due_replies.pop_front();
      n_checked++;
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("slot", 8'(want.slot), 8'(got.slot));
      compare_field("step_number", want.step_number, got.step_number);
      compare_field("live_count", want.live_count, got.live_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bsa_req_if req ();
  bsa_rsp_if rsp ();

  bitmap_slot_alloc_ordered_insert_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  slot_ledger sb;
  bit         calm;
  int         n_sent;
  int         cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one; none in calm stretches
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer(input logic kind, input logic [POS_W-1:0] pos);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.req_type <= kind;
    req.position <= pos;
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.note_request(kind, pos);
    n_sent++;
  endtask

  task automatic offer_insert(input logic [POS_W-1:0] pos);
    offer(REQ_INSERT, pos);
  endtask

  task automatic offer_clear();
    offer(REQ_CLEAR, POS_W'($urandom));
  endtask

  // picks a position, half of the time within the current list
  function automatic logic [POS_W-1:0] pick_pos();
    int lim;
    lim = (int'(sb.step_total) > SLOTS - 1) ? SLOTS - 1 : int'(sb.step_total);
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, lim));
    return POS_W'($urandom);
  endfunction

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("bitmap_slot_alloc_ordered_insert_top regression: fail");
    $finish;
  end

  initial begin : drain
    int     stall_left;
    bit     held_long;
    reply_t got;
    stall_left = 0;
    held_long  = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got.status      = rsp.status;
        got.slot        = rsp.slot;
        got.step_number = rsp.step_number;
        got.live_count  = rsp.live_count;
        sb.check_reply(got);
      end
      if (rst) begin
        rsp.ready <= 1'b0;
      end else if (!held_long && sb.n_checked >= HOLD_AFTER) begin
        // long back-pressure so the request side fills up and stalls
        held_long  = 1'b1;
        stall_left = HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    int run;
    sb     = new();
    calm   = 1'b0;
    n_sent = 0;
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.req_type <= REQ_INSERT;
    req.position <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, append, front and middle shifts, beyond-count, clears
    offer_insert(7'd0);
    offer_insert(7'd127);
    offer_insert(7'd1);
    offer_insert(7'd0);
    offer_insert(7'd4);
    offer_insert(7'd2);
    offer_insert(7'h55);
    offer_insert(7'h2a);
    offer_insert(7'd0);
    offer_clear();
    offer_clear();
    offer_insert(7'd127);
    offer_insert(7'd64);
    offer_insert(7'd0);
    offer_clear();
    offer_insert(7'd3);
    offer_clear();

    // fill every slot, then a few more to hit the no free slot case
    calm = 1'b1;
    for (int k = 0; k < SLOTS + 3; k++) offer_insert(pick_pos());
    calm = 1'b0;
    offer_insert(7'd127);
    offer_clear();

    while (n_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) run = $urandom_range(SLOTS, SLOTS + 6);
      else run = $urandom_range(1, 40);
      for (int k = 0; k < run; k++) begin
        if ($urandom_range(0, 24) == 0) offer_clear();
        else offer_insert(pick_pos());
      end
      offer_clear();
    end
    req.valid <= 1'b0;

    while (sb.due_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests: %0d placed, %0d clears, %0d rejected as full",
             n_sent, sb.n_placed, sb.n_clears, sb.n_full);
    $display("deepest list %0d steps, %0d words checked, %0d mismatches",
             sb.deepest, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("bitmap_slot_alloc_ordered_insert_top regression: pass");
    end else begin
      $display("bitmap_slot_alloc_ordered_insert_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_req_if.sv
hw/rtl/bsa_rsp_if.sv
hw/rtl/bsa_ctrl.sv
hw/rtl/bsa_datapath.sv
hw/rtl/bitmap_slot_alloc_ordered_insert_top.sv
hw/rtl/bsa_checker.sv
verif/bitmap_slot_alloc_ordered_insert_top_tb.sv
